/* rtl/core/chps_pkg.sv */
// Shared types and constants for the chained hash set.
// Holds the request classes and the table of growth primes.
// No dependencies.
`default_nettype none

package chps_pkg;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    localparam int START_BUCKETS = 11;
    localparam int TOTAL_W       = 11;
    localparam int PRIME_COUNT   = 14;
    localparam int PRIME_W       = 17;

    localparam logic [PRIME_W-1:0] GROW_PRIMES [PRIME_COUNT] = '{
        17'd11, 17'd19, 17'd37, 17'd67, 17'd131, 17'd283, 17'd521,
        17'd1033, 17'd2053, 17'd4099, 17'd8219, 17'd16427,
        17'd32771, 17'd65581
    };

    // First prime whose power-of-two base exceeds count plus one; zero if none.
    function automatic logic [PRIME_W-1:0] grow_prime(input logic [PRIME_W-1:0] count);
        logic [PRIME_W:0]   limit;
        logic [PRIME_W-1:0] pick;
        logic               hit;
        limit = {1'b0, count} + 18'd1;
        pick  = '0;
        hit   = 1'b0;
        for (int i = 0; i < PRIME_COUNT; i++)
        begin
            if (!hit && ((18'd8 << i) > limit))
            begin
                pick = GROW_PRIMES[i];
                hit  = 1'b1;
            end
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/chps_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module chps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/chps_mod.sv */
// Iterative remainder unit: key modulo bucket count, four bits per cycle.
// No package dependencies.
`default_nettype none

module chps_mod #(
    parameter int KEY_BITS = 64,
    parameter int DW       = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [KEY_BITS-1:0] dividend,
    input  wire logic [DW-1:0]       divisor,
    output logic                     done,
    output logic      [DW-1:0]       rem
);

    localparam int STEPS = (KEY_BITS + 3) / 4;
    localparam int PADW  = STEPS * 4;
    localparam int CW    = $clog2(STEPS + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [PADW-1:0] num_reg;
    logic [DW-1:0]   div_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   rem_next;

    always_comb
    begin
        logic [DW:0] t;
        rem_next = rem_reg;
        for (int k = 0; k < 4; k++)
        begin
            t = {rem_next, num_reg[PADW-1-k]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            rem_next = t[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= PADW'(dividend);
                div_reg  <= divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 4;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* rtl/core/chps_front.sv */
// Front end: takes request items, classifies them and queues them two deep.
// Depends on chps_pkg.
`default_nettype none

module chps_front
    import chps_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          req_type,
    input  wire logic [63:0]         element,
    output logic                     q_valid,
    output op_t                      q_op,
    output logic      [KEY_BITS-1:0] q_key,
    input  wire logic                q_pop
);

    op_t               op_q  [2];
    logic [KEY_BITS-1:0] key_q [2];
    logic [1:0]        count_reg;
    logic              rd_ptr_reg;
    logic              wr_ptr_reg;
    logic              push;
    op_t               op_class;

    always_comb
    begin
        case (req_type)
            2'd0:    op_class = OP_INSERT;
            2'd1:    op_class = OP_DELETE;
            2'd2:    op_class = OP_CONTAINS;
            default: op_class = OP_CLEAR;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_op     = op_q[rd_ptr_reg];
    assign q_key    = key_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg]  <= op_class;
            key_q[wr_ptr_reg] <= element[KEY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/chps_back.sv */
// Back end: walks bucket chains, inserts, unlinks, clears and rehashes.
// Depends on chps_pkg, chps_ram and chps_mod.
`default_nettype none

module chps_back
    import chps_pkg::*;
#(
    parameter int ENTRY_SLOTS  = 1024,
    parameter int BUCKET_SLOTS = 1024,
    parameter int KEY_BITS     = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire op_t                 q_op,
    input  wire logic [KEY_BITS-1:0] q_key,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     found,
    output logic                     status,
    output logic      [TOTAL_W-1:0]  entry_total,
    output logic      [TOTAL_W-1:0]  bucket_total
);

    localparam int IW     = $clog2(ENTRY_SLOTS);
    localparam int PW     = $clog2(ENTRY_SLOTS + 1);
    localparam int DW     = $clog2(BUCKET_SLOTS + 1);
    localparam int BIW    = $clog2(BUCKET_SLOTS);
    localparam int HDEPTH = 2 * (1 << BIW);
    localparam logic [PW-1:0] NONE = PW'(ENTRY_SLOTS);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_BIN, S_HEAD, S_WALK, S_CMP, S_ACT, S_DEL2,
        S_IRD, S_IWR, S_GCLR, S_GHEAD, S_GHD2, S_GWALK, S_GKEY, S_GMOD,
        S_GLINK, S_REBIN, S_IBIN
    } state_t;

    state_t              state_reg;
    logic                reply_reg;
    logic                bank_reg;
    logic [DW-1:0]       bcount_reg;
    logic [PW-1:0]       ecount_reg;
    logic [PW-1:0]       free_head_reg;
    logic [PW-1:0]       fresh_reg;
    op_t                 op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [BIW-1:0]      bin_reg;
    logic [BIW-1:0]      nb_reg;
    logic [PW-1:0]       e_reg;
    logic [PW-1:0]       prev_reg;
    logic [PW-1:0]       hit_link_reg;
    logic [PW-1:0]       next_reg;
    logic [DW-1:0]       target_reg;
    logic [DW-1:0]       idx_reg;
    logic                found_reg;

    logic                out_valid_reg;
    logic                found_out_reg;
    logic                status_out_reg;
    logic [TOTAL_W-1:0]  etotal_reg;
    logic [TOTAL_W-1:0]  btotal_reg;

    logic                key_we;
    logic [IW-1:0]       key_waddr;
    logic [IW-1:0]       key_raddr;
    logic [KEY_BITS-1:0] key_rdata;
    logic                link_we;
    logic [IW-1:0]       link_waddr;
    logic [PW-1:0]       link_wdata;
    logic [IW-1:0]       link_raddr;
    logic [PW-1:0]       link_rdata;
    logic                head_we;
    logic [BIW:0]        head_waddr;
    logic [PW-1:0]       head_wdata;
    logic [BIW:0]        head_raddr;
    logic [PW-1:0]       head_rdata;

    logic                mod_start;
    logic [KEY_BITS-1:0] mod_dividend;
    logic [DW-1:0]       mod_divisor;
    logic                mod_done;
    logic [DW-1:0]       mod_rem;

    logic                out_free;
    logic [PRIME_W-1:0]  grow_tgt;
    logic                grow_ok;
    logic                pool_full;
    logic [PW-1:0]       free_next;

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && out_free;
    assign grow_tgt  = grow_prime(PRIME_W'(bcount_reg));
    assign grow_ok   = (18'(ecount_reg) > (18'(bcount_reg) << 1)) && (grow_tgt != '0)
                       && (grow_tgt <= PRIME_W'(BUCKET_SLOTS));
    assign pool_full = (ecount_reg >= NONE) || (free_head_reg >= NONE);
    // Slots at or above the fresh mark have never been used and link to the next slot.
    assign free_next = (free_head_reg == fresh_reg) ? free_head_reg + PW'(1) : link_rdata;

    chps_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRY_SLOTS)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (key_reg),
        .rd_addr (key_raddr),
        .rd_data (key_rdata)
    );

    chps_ram #(.WIDTH(PW), .DEPTH(ENTRY_SLOTS)) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    // Two banks of bucket heads; the bank bit picks the live one, a rehash fills the other.
    chps_ram #(.WIDTH(PW), .DEPTH(HDEPTH)) u_head_ram (
        .clk     (clk),
        .wr_en   (head_we),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_addr (head_raddr),
        .rd_data (head_rdata)
    );

    chps_mod #(.KEY_BITS(KEY_BITS), .DW(DW)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        key_we       = 1'b0;
        key_waddr    = e_reg[IW-1:0];
        key_raddr    = e_reg[IW-1:0];
        link_we      = 1'b0;
        link_waddr   = e_reg[IW-1:0];
        link_wdata   = head_rdata;
        link_raddr   = e_reg[IW-1:0];
        head_we      = 1'b0;
        head_waddr   = {bank_reg, bin_reg};
        head_wdata   = NONE;
        head_raddr   = {bank_reg, bin_reg};
        mod_start    = 1'b0;
        mod_dividend = q_key;
        mod_divisor  = bcount_reg;
        case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = {bank_reg, idx_reg[BIW-1:0]};
            end
            S_IDLE:
            begin
                mod_start = q_pop && (q_op != OP_CLEAR);
            end
            S_BIN:
            begin
                head_raddr = {bank_reg, mod_rem[BIW-1:0]};
            end
            S_ACT:
            begin
                if (op_reg == OP_DELETE && found_reg)
                begin
                    if (prev_reg >= NONE)
                    begin
                        head_we    = 1'b1;
                        head_wdata = hit_link_reg;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[IW-1:0];
                        link_wdata = hit_link_reg;
                    end
                end
            end
            S_DEL2:
            begin
                link_we    = 1'b1;
                link_wdata = free_head_reg;
            end
            S_IRD:
            begin
                link_raddr = free_head_reg[IW-1:0];
            end
            S_IWR:
            begin
                key_we     = 1'b1;
                key_waddr  = free_head_reg[IW-1:0];
                link_we    = 1'b1;
                link_waddr = free_head_reg[IW-1:0];
                head_we    = 1'b1;
                head_wdata = free_head_reg;
            end
            S_GCLR:
            begin
                head_we    = 1'b1;
                head_waddr = {!bank_reg, idx_reg[BIW-1:0]};
            end
            S_GHEAD:
            begin
                head_raddr = {bank_reg, idx_reg[BIW-1:0]};
            end
            S_GKEY:
            begin
                mod_start    = 1'b1;
                mod_dividend = key_rdata;
                mod_divisor  = target_reg;
            end
            S_GMOD:
            begin
                head_raddr = {!bank_reg, mod_rem[BIW-1:0]};
            end
            S_GLINK:
            begin
                link_we    = 1'b1;
                head_we    = 1'b1;
                head_waddr = {!bank_reg, nb_reg};
                head_wdata = e_reg;
            end
            S_REBIN:
            begin
                mod_start    = 1'b1;
                mod_dividend = key_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            reply_reg     <= 1'b0;
            bank_reg      <= 1'b0;
            bcount_reg    <= DW'(START_BUCKETS);
            ecount_reg    <= '0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + DW'(1);
                    if (idx_reg == DW'(START_BUCKETS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                        if (reply_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            found_out_reg  <= 1'b0;
                            status_out_reg <= 1'b0;
                            etotal_reg     <= '0;
                            btotal_reg     <= TOTAL_W'(START_BUCKETS);
                        end
                    end
                end
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        op_reg  <= q_op;
                        key_reg <= q_key;
                        if (q_op == OP_CLEAR)
                        begin
                            reply_reg     <= 1'b1;
                            bcount_reg    <= DW'(START_BUCKETS);
                            ecount_reg    <= '0;
                            free_head_reg <= '0;
                            fresh_reg     <= '0;
                            idx_reg       <= '0;
                            state_reg     <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_BIN;
                        end
                    end
                end
                S_BIN:
                begin
                    if (mod_done)
                    begin
                        bin_reg   <= mod_rem[BIW-1:0];
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    e_reg     <= head_rdata;
                    prev_reg  <= NONE;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (e_reg >= NONE)
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (key_rdata == key_reg)
                    begin
                        found_reg    <= 1'b1;
                        hit_link_reg <= link_rdata;
                        state_reg    <= S_ACT;
                    end
                    else
                    begin
                        prev_reg  <= e_reg;
                        e_reg     <= link_rdata;
                        state_reg <= S_WALK;
                    end
                end
                S_ACT:
                begin
                    if (op_reg == OP_INSERT && !found_reg && !pool_full)
                    begin
                        if (grow_ok)
                        begin
                            target_reg <= grow_tgt[DW-1:0];
                            idx_reg    <= '0;
                            state_reg  <= S_GCLR;
                        end
                        else
                        begin
                            state_reg <= S_IRD;
                        end
                    end
                    else if (op_reg == OP_DELETE && found_reg)
                    begin
                        state_reg <= S_DEL2;
                    end
                    else
                    begin
                        out_valid_reg  <= 1'b1;
                        found_out_reg  <= found_reg;
                        status_out_reg <= (op_reg == OP_INSERT) && !found_reg;
                        etotal_reg     <= TOTAL_W'(ecount_reg);
                        btotal_reg     <= TOTAL_W'(bcount_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                S_DEL2:
                begin
                    free_head_reg  <= e_reg;
                    ecount_reg     <= ecount_reg - PW'(1);
                    out_valid_reg  <= 1'b1;
                    found_out_reg  <= 1'b1;
                    status_out_reg <= 1'b0;
                    etotal_reg     <= TOTAL_W'(ecount_reg - PW'(1));
                    btotal_reg     <= TOTAL_W'(bcount_reg);
                    state_reg      <= S_IDLE;
                end
                S_IRD:
                begin
                    state_reg <= S_IWR;
                end
                S_IWR:
                begin
                    if (free_head_reg == fresh_reg)
                    begin
                        fresh_reg <= fresh_reg + PW'(1);
                    end
                    free_head_reg  <= free_next;
                    ecount_reg     <= ecount_reg + PW'(1);
                    out_valid_reg  <= 1'b1;
                    found_out_reg  <= 1'b0;
                    status_out_reg <= 1'b0;
                    etotal_reg     <= TOTAL_W'(ecount_reg + PW'(1));
                    btotal_reg     <= TOTAL_W'(bcount_reg);
                    state_reg      <= S_IDLE;
                end
                S_GCLR:
                begin
                    idx_reg <= idx_reg + DW'(1);
                    if (idx_reg == target_reg - DW'(1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_GHEAD;
                    end
                end
                S_GHEAD:
                begin
                    state_reg <= S_GHD2;
                end
                S_GHD2:
                begin
                    e_reg     <= head_rdata;
                    state_reg <= S_GWALK;
                end
                S_GWALK:
                begin
                    if (e_reg >= NONE)
                    begin
                        if (idx_reg == bcount_reg - DW'(1))
                        begin
                            bank_reg   <= !bank_reg;
                            bcount_reg <= target_reg;
                            state_reg  <= S_REBIN;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + DW'(1);
                            state_reg <= S_GHEAD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_GKEY;
                    end
                end
                S_GKEY:
                begin
                    next_reg  <= link_rdata;
                    state_reg <= S_GMOD;
                end
                S_GMOD:
                begin
                    if (mod_done)
                    begin
                        nb_reg    <= mod_rem[BIW-1:0];
                        state_reg <= S_GLINK;
                    end
                end
                S_GLINK:
                begin
                    e_reg     <= next_reg;
                    state_reg <= S_GWALK;
                end
                S_REBIN:
                begin
                    state_reg <= S_IBIN;
                end
                S_IBIN:
                begin
                    if (mod_done)
                    begin
                        bin_reg   <= mod_rem[BIW-1:0];
                        state_reg <= S_IRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_out_reg;
    assign status       = status_out_reg;
    assign entry_total  = etotal_reg;
    assign bucket_total = btotal_reg;

endmodule

`default_nettype wire

/* rtl/core/chained_hash_pointer_set_top.sv */
// Top level of the chained hash set: request queue front end and chain-walking back end.
// Depends on chps_pkg, chps_front and chps_back.
//
//   Channel   Direction  Handshake            Fields
//   request   in         in_valid/in_stall    req_type, element
//   result    out        out_valid/out_stall  found, status, entry_total, bucket_total
//
// A lookup first reduces the key to a bucket in the remainder unit (four key bits per cycle),
// then visits the chain entries of that bucket one by one and acts on the result.
// Growth clears each new bucket, walks each old bucket and relinks every entry it finds.
// After reset, and after a clear request, the live bucket heads are swept before work resumes.
// Two request items queue in front of the back end, which takes none while a result is held.
`default_nettype none

module chained_hash_pointer_set_top
    import chps_pkg::*;
#(
    parameter int ENTRY_SLOTS  = 1024,
    parameter int BUCKET_SLOTS = 1024,
    parameter int KEY_BITS     = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [63:0]        element,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    found,
    output logic                    status,
    output logic      [TOTAL_W-1:0] entry_total,
    output logic      [TOTAL_W-1:0] bucket_total
);

    logic                q_valid;
    op_t                 q_op;
    logic [KEY_BITS-1:0] q_key;
    logic                q_pop;

    chps_front #(.KEY_BITS(KEY_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .element  (element),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_key    (q_key),
        .q_pop    (q_pop)
    );

    chps_back #(
        .ENTRY_SLOTS  (ENTRY_SLOTS),
        .BUCKET_SLOTS (BUCKET_SLOTS),
        .KEY_BITS     (KEY_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_op         (q_op),
        .q_key        (q_key),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .status       (status),
        .entry_total  (entry_total),
        .bucket_total (bucket_total)
    );

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_full_queue_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_valid)
        else $error("input stalled with nothing queued");

    a_refused_means_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !found)
        else $error("insert refused for a key already held");

    a_pop_after_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("back end took two items in consecutive cycles");

endmodule

`default_nettype wire

/* dv/tb_chained_hash_pointer_set_top.sv */
// Self-checking testbench for the chained hash set: directed table, then random traffic.
// Predicts each result with its own model of the buckets and free list; depends on chps_pkg.
`default_nettype none

module tb_chained_hash_pointer_set_top;
    import chps_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int BINS       = 1024;
    localparam int EMPTY      = SLOTS;
    localparam int STALL_MAX  = 60000;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic        found;
        logic        status;
        logic [10:0] entries;
        logic [10:0] buckets;
    } result_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] key;
        logic        fixed;
        result_t     want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [63:0] element;
    logic        out_valid;
    logic        out_stall;
    logic        found;
    logic        status;
    logic [10:0] entry_total;
    logic [10:0] bucket_total;

    chained_hash_pointer_set_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .element      (element),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .status       (status),
        .entry_total  (entry_total),
        .bucket_total (bucket_total)
    );

    // Shadow copy of the set.
    logic [63:0] key_mem [SLOTS];
    int unsigned next_of [SLOTS];
    int unsigned chain_top [BINS];
    int unsigned held_count;
    int unsigned bin_count;
    int unsigned free_top;

    result_t     pending_q [$];
    logic [63:0] live_keys [$];
    int          errors = 0;
    bit          quiet;
    bit          cur_fixed;
    result_t     cur_want;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic void clear_shadow();
        for (int i = 0; i < SLOTS; i++)
        begin
            key_mem[i] = '0;
            next_of[i] = i + 1;
        end
        for (int i = 0; i < BINS; i++)
        begin
            chain_top[i] = EMPTY;
        end
        held_count = 0;
        bin_count  = 11;
        free_top   = 0;
    endfunction

    // Rehash every held key into the next table size, if one fits.
    function automatic void rehash_shadow();
        int unsigned sizes [14] = '{11, 19, 37, 67, 131, 283, 521, 1033, 2053, 4099,
                                    8219, 16427, 32771, 65581};
        int unsigned fresh [BINS];
        int unsigned target;
        int unsigned e;
        int unsigned nxt;
        int unsigned nb;
        target = 0;
        for (int i = 0; i < 14; i++)
        begin
            if (target == 0 && (8 << i) > bin_count + 1)
                target = sizes[i];
        end
        if (target == 0 || target > BINS)
            return;
        for (int i = 0; i < BINS; i++)
            fresh[i] = EMPTY;
        for (int i = 0; i < bin_count; i++)
        begin
            e = chain_top[i];
            while (e < SLOTS)
            begin
                nxt        = next_of[e];
                nb         = 32'(key_mem[e] % 64'(target));
                next_of[e] = fresh[nb];
                fresh[nb]  = e;
                e          = nxt;
            end
        end
        chain_top = fresh;
        bin_count = target;
    endfunction

    function automatic result_t apply_request(op_t op, logic [63:0] key);
        result_t     r;
        int unsigned bin;
        int unsigned e;
        int unsigned prev;
        int unsigned slot;
        r = '0;
        if (op == OP_CLEAR)
        begin
            clear_shadow();
        end
        else
        begin
            bin  = 32'(key % 64'(bin_count));
            e    = chain_top[bin];
            prev = EMPTY;
            while (e < SLOTS && key_mem[e] != key)
            begin
                prev = e;
                e    = next_of[e];
            end
            r.found = (e < SLOTS);
            if (op == OP_INSERT && !r.found)
            begin
                if (held_count >= SLOTS || free_top >= SLOTS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    if (held_count > 2 * bin_count)
                        rehash_shadow();
                    bin             = 32'(key % 64'(bin_count));
                    slot            = free_top;
                    free_top        = next_of[slot];
                    key_mem[slot]   = key;
                    next_of[slot]   = chain_top[bin];
                    chain_top[bin]  = slot;
                    held_count++;
                end
            end
            else if (op == OP_DELETE && r.found)
            begin
                if (prev == EMPTY)
                    chain_top[bin] = next_of[e];
                else
                    next_of[prev] = next_of[e];
                next_of[e] = free_top;
                free_top   = e;
                held_count--;
            end
        end
        r.entries = held_count[10:0];
        r.buckets = bin_count[10:0];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Accepted items are sampled here; a row with a fixed result overrides the prediction.
    always @(posedge clk)
    begin
        result_t r;
        result_t w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r = apply_request(op_t'(req_type), element);
                pending_q.push_back(cur_fixed ? cur_want : r);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual found %0b status %0b",
                             $time, found, status);
                    errors++;
                end
                else
                begin
                    w = pending_q.pop_front();
                    check_field("found", 32'(w.found), 32'(found));
                    check_field("status", 32'(w.status), 32'(status));
                    check_field("entry_total", 32'(w.entries), 32'(entry_total));
                    check_field("bucket_total", 32'(w.buckets), 32'(bucket_total));
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    int idle_run;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run > STALL_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure in bursts.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(op_t op, logic [63:0] key, bit fixed, result_t want);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_type  <= op;
        element   <= key;
        cur_fixed <= fixed;
        cur_want  <= want;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    row_t plan [20] = '{
        '{OP_CONTAINS, 64'd0,     1'b1, '{1'b0, 1'b0, 11'd0, 11'd11}},
        '{OP_DELETE,   64'd0,     1'b1, '{1'b0, 1'b0, 11'd0, 11'd11}},
        '{OP_INSERT,   64'd0,     1'b1, '{1'b0, 1'b0, 11'd1, 11'd11}},
        '{OP_INSERT,   64'd0,     1'b1, '{1'b1, 1'b0, 11'd1, 11'd11}},
        '{OP_INSERT,   '1,        1'b1, '{1'b0, 1'b0, 11'd2, 11'd11}},
        '{OP_CONTAINS, '1,        1'b1, '{1'b1, 1'b0, 11'd2, 11'd11}},
        '{OP_DELETE,   64'd5,     1'b1, '{1'b0, 1'b0, 11'd2, 11'd11}},
        '{OP_DELETE,   64'd0,     1'b1, '{1'b1, 1'b0, 11'd1, 11'd11}},
        '{OP_CLEAR,    '1,        1'b1, '{1'b0, 1'b0, 11'd0, 11'd11}},
        '{OP_CONTAINS, '1,        1'b1, '{1'b0, 1'b0, 11'd0, 11'd11}},
        // Three keys sharing one bucket, then unlink from the middle and the head.
        '{OP_INSERT,   64'd11,    1'b0, '0},
        '{OP_INSERT,   64'd22,    1'b0, '0},
        '{OP_INSERT,   64'd33,    1'b0, '0},
        '{OP_DELETE,   64'd22,    1'b0, '0},
        '{OP_CONTAINS, 64'd33,    1'b0, '0},
        '{OP_DELETE,   64'd33,    1'b0, '0},
        '{OP_CONTAINS, 64'd11,    1'b0, '0},
        '{OP_INSERT,   64'h8000_0000_0000_0000, 1'b0, '0},
        '{OP_DELETE,   64'd11,    1'b0, '0},
        '{OP_CONTAINS, 64'h8000_0000_0000_0000, 1'b0, '0}
    };

    initial
    begin
        logic [63:0] pool [16];
        logic [63:0] k;
        op_t         op;
        quiet     = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = OP_INSERT;
        element   = '0;
        cur_fixed = 1'b0;
        cur_want  = '0;
        clear_shadow();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            send(plan[i].op, plan[i].key, plan[i].fixed, plan[i].want);

        // Let everything drain before the random traffic starts.
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        @(negedge clk);

        // Mixed traffic over a small key pool so that hits and misses both occur.
        foreach (pool[i])
            pool[i] = (i < 2) ? (i == 0 ? 64'd0 : '1) : rand_key();
        for (int n = 0; n < 60; n++)
        begin
            op = op_t'($urandom_range(0, 2));
            if ($urandom_range(0, 39) == 0)
                op = OP_CLEAR;
            k = ($urandom_range(0, 7) == 0) ? rand_key() : pool[$urandom_range(0, 15)];
            send(op, k, 1'b0, '0);
        end

        // Fill the pool past capacity; the table grows on the way and refusals follow.
        send(OP_CLEAR, rand_key(), 1'b0, '0);
        while (live_keys.size() < 1040)
        begin
            k = rand_key();
            if ($urandom_range(0, 39) == 0)
                send(OP_CONTAINS, (live_keys.size() != 0 && $urandom_range(0, 1))
                     ? live_keys[$urandom_range(0, live_keys.size() - 1)] : k, 1'b0, '0);
            else
            begin
                live_keys.push_back(k);
                send(OP_INSERT, k, 1'b0, '0);
            end
        end

        // Free and reuse slots in a full table, with no idling on either side.
        quiet = 1'b1;
        for (int n = 0; n < 40; n++)
        begin
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            send(op_t'($urandom_range(0, 2)), k, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
